FILE: rtl/uvd_pkg.sv
`timescale 1ns / 1ps
// Shared types, rule codes and range checks for the UTF-8 validating decoder.
package uvd_pkg;

  // Allowed range of the next continuation byte.
  localparam logic [2:0] RULE_ANY = 3'd0;  // 80-BF
  localparam logic [2:0] RULE_E0  = 3'd1;  // A0-BF
  localparam logic [2:0] RULE_ED  = 3'd2;  // 80-9F
  localparam logic [2:0] RULE_F0  = 3'd3;  // 90-BF
  localparam logic [2:0] RULE_F4  = 3'd4;  // 80-8F

  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;

  typedef struct packed {
    logic [20:0] partial_value;
    logic [1:0]  bytes_owed;
    logic [2:0]  sequence_length;
    logic [2:0]  second_byte_rule;
    logic        discarding;
  } dec_state_t;

  typedef struct packed {
    logic        emit;
    logic [20:0] code_point;
    logic        malformed;
    logic [2:0]  byte_count;
    logic        end_of_text;
  } step_res_t;

  function automatic logic cont_ok(input logic [7:0] b, input logic [2:0] rule);
    logic ok;
    case (rule)
      RULE_E0: ok = b inside {[8'hA0:8'hBF]};
      RULE_ED: ok = b inside {[8'h80:8'h9F]};
      RULE_F0: ok = b inside {[8'h90:8'hBF]};
      RULE_F4: ok = b inside {[8'h80:8'h8F]};
      default: ok = b inside {[8'h80:8'hBF]};
    endcase
    return ok;
  endfunction

endpackage

FILE: rtl/uvd_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the byte input and the decode result.
interface uvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface uvd_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        malformed;
  logic [2:0]  byte_count;
  logic        end_of_text;

  modport source (output valid, output code_point, output malformed,
                  output byte_count, output end_of_text, input ready);
  modport sink   (input valid, input code_point, input malformed,
                  input byte_count, input end_of_text, output ready);
endinterface

FILE: rtl/uvd_step.sv
`timescale 1ns / 1ps
// Combinational decode step: one byte against the current decoder state.
module uvd_step (
  input  uvd_pkg::dec_state_t cur,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output uvd_pkg::dec_state_t nxt,
  output uvd_pkg::step_res_t  res
);

  logic [20:0] shifted;
  logic [2:0]  seq_inc;
  logic [1:0]  owed_dec;
  logic        fail;
  logic [2:0]  fail_count;

  assign shifted  = {cur.partial_value[14:0], data_byte[5:0]};
  assign seq_inc  = cur.sequence_length + 3'd1;
  assign owed_dec = cur.bytes_owed - 2'd1;

  always_comb begin
    nxt        = cur;
    res        = '0;
    fail       = 1'b0;
    fail_count = 3'd1;

    if (cur.discarding) begin
      // drop until end of text
      nxt.discarding = ~last_byte;
    end else if (cur.bytes_owed == 2'd0) begin
      if (data_byte[7] == 1'b0) begin
        res.emit       = 1'b1;
        res.code_point = {13'd0, data_byte};
        res.byte_count = 3'd1;
      end else if (data_byte inside {[8'hC2:8'hDF]}) begin
        nxt.partial_value    = {16'd0, data_byte[4:0]};
        nxt.bytes_owed       = 2'd1;
        nxt.second_byte_rule = uvd_pkg::RULE_ANY;
        nxt.sequence_length  = 3'd1;
        fail                 = last_byte;
      end else if (data_byte inside {[8'hE0:8'hEF]}) begin
        nxt.partial_value    = {17'd0, data_byte[3:0]};
        nxt.bytes_owed       = 2'd2;
        nxt.second_byte_rule = (data_byte == uvd_pkg::LEAD_E0) ? uvd_pkg::RULE_E0 :
                               (data_byte == uvd_pkg::LEAD_ED) ? uvd_pkg::RULE_ED :
                                                                 uvd_pkg::RULE_ANY;
        nxt.sequence_length  = 3'd1;
        fail                 = last_byte;
      end else if (data_byte inside {[8'hF0:8'hF4]}) begin
        nxt.partial_value    = {18'd0, data_byte[2:0]};
        nxt.bytes_owed       = 2'd3;
        nxt.second_byte_rule = (data_byte == uvd_pkg::LEAD_F0) ? uvd_pkg::RULE_F0 :
                               (data_byte == uvd_pkg::LEAD_F4) ? uvd_pkg::RULE_F4 :
                                                                 uvd_pkg::RULE_ANY;
        nxt.sequence_length  = 3'd1;
        fail                 = last_byte;
      end else begin
        fail = 1'b1;
      end
    end else begin
      fail_count = seq_inc;
      if (!uvd_pkg::cont_ok(data_byte, cur.second_byte_rule)) begin
        fail = 1'b1;
      end else if (owed_dec == 2'd0) begin
        res.emit       = 1'b1;
        res.code_point = shifted;
        res.byte_count = seq_inc;
        nxt.partial_value    = '0;
        nxt.bytes_owed       = '0;
        nxt.sequence_length  = '0;
        nxt.second_byte_rule = uvd_pkg::RULE_ANY;
      end else begin
        nxt.partial_value    = shifted;
        nxt.bytes_owed       = owed_dec;
        nxt.sequence_length  = seq_inc;
        nxt.second_byte_rule = uvd_pkg::RULE_ANY;
        fail                 = last_byte;
      end
    end

    if (fail) begin
      nxt.partial_value    = '0;
      nxt.bytes_owed       = '0;
      nxt.sequence_length  = '0;
      nxt.second_byte_rule = uvd_pkg::RULE_ANY;
      nxt.discarding       = ~last_byte;
      res.emit             = 1'b1;
      res.code_point       = '0;
      res.malformed        = 1'b1;
      res.byte_count       = fail_count;
    end

    res.end_of_text = last_byte;
  end

endmodule

FILE: rtl/utf8_validating_decoder_unit.sv
`timescale 1ns / 1ps
// Top level of the UTF-8 validating decoder: input register, decode step, result register.
//
// Feed the text one byte per request on in_ch, with last_byte set on its final
// byte. The unit takes one byte every cycle unless out_ch stalls it, and returns
// a result on out_ch after the byte passes the input register and then the
// result register. A result carries the Unicode scalar value of a completed
// sequence, or malformed=1 (code_point 0) for a bad lead byte, a bad or
// restricted continuation byte (E0, ED, F0, F4 second-byte rules), or a text
// that ends with a sequence still open. byte_count gives the bytes of the
// sequence up to and including the byte that produced the result. After an
// error the unit drops bytes silently until the byte flagged last_byte, which
// itself gives no result. Bytes that only extend a sequence produce no result.
// The throughput is set by the single decode step between the two registers;
// backpressure on out_ch stalls the input only when a byte has a result ready
// and the result register is still occupied.
module utf8_validating_decoder_unit (
  input logic    clk,
  input logic    rst_n,
  uvd_in_if.sink    in_ch,
  uvd_out_if.source out_ch
);

  // Input register
  logic       in_valid_r;
  logic [7:0] in_data_r;
  logic       in_last_r;

  // Decoder state
  uvd_pkg::dec_state_t state_r;
  uvd_pkg::dec_state_t state_nxt;
  uvd_pkg::step_res_t  step_res;

  // Result register
  logic        out_valid_r;
  logic [20:0] out_code_point_r;
  logic        out_malformed_r;
  logic [2:0]  out_byte_count_r;
  logic        out_end_of_text_r;

  logic advance;

  uvd_step u_step (
    .cur       (state_r),
    .data_byte (in_data_r),
    .last_byte (in_last_r),
    .nxt       (state_nxt),
    .res       (step_res)
  );

  // Advance the held byte unless it has a result and the result slot is blocked.
  assign advance      = in_valid_r && (!step_res.emit || !out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_data_r <= in_ch.data_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && step_res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load the result payload; hold it while the request waits.
  always_ff @(posedge clk) begin
    if (advance && step_res.emit) begin
      out_code_point_r  <= step_res.code_point;
      out_malformed_r   <= step_res.malformed;
      out_byte_count_r  <= step_res.byte_count;
      out_end_of_text_r <= step_res.end_of_text;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_point  = out_code_point_r;
  assign out_ch.malformed   = out_malformed_r;
  assign out_ch.byte_count  = out_byte_count_r;
  assign out_ch.end_of_text = out_end_of_text_r;

  // A malformed result never carries a code point.
  a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_malformed_r |-> out_code_point_r == 21'd0)
    else $error("malformed result with nonzero code point");

  // Byte count of any result lies in 1..4.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_byte_count_r != 3'd0) && (out_byte_count_r <= 3'd4))
    else $error("result byte count out of range");

  // A valid result is a scalar value: no surrogate, nothing above 10FFFF.
  a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_malformed_r |->
      (out_code_point_r <= 21'h10FFFF) &&
      !((out_code_point_r >= 21'h00D800) && (out_code_point_r <= 21'h00DFFF)))
    else $error("valid result is not a Unicode scalar value");

  // While dropping bytes no sequence is open.
  a_discard_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.discarding |-> (state_r.bytes_owed == 2'd0) && (state_r.sequence_length == 3'd0))
    else $error("sequence state left open while discarding");

endmodule
